/* design/tlrg_pkg.sv */
package tlrg_pkg;

   // largest pixel index plus one; larger indexes clamp
   localparam int MAX_IMAGE_SIDE = 4096;

   localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

   // register indexes of the csr port
   localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
   localparam logic [2:0] REG_HALF_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_PIXEL_SIZE_X = 3'd2;
   localparam logic [2:0] REG_PIXEL_SIZE_Y = 3'd3;
   localparam logic [2:0] REG_APERTURE     = 3'd4;
   localparam logic [2:0] REG_FOCAL_LEN    = 3'd5;
   localparam logic [2:0] REG_SENSOR_DIST  = 3'd6;

   // one root bit per square root stage, one quotient bit per divide stage
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   // fields carried alongside the normalization pipeline
   typedef struct packed {
      logic [31:0] ox;
      logic [31:0] oz;
      logic [2:0]  neg;
      logic        zero;
   } side_type;

   // apply sign to a magnitude and saturate to signed 32 bit
   function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
      logic [31:0] r;
      if (neg) begin
         r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
      end else begin
         r = (m > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff : m[31:0];
      end
      return r;
   endfunction

   // pixel index clamp
   function automatic logic [11:0] clamp_pixel(input logic [11:0] p);
      logic [11:0] r;
      if (int'(p) >= MAX_IMAGE_SIDE) begin
         r = 12'(MAX_IMAGE_SIDE - 1);
      end else begin
         r = p;
      end
      return r;
   endfunction

endpackage

/* design/thin_lens_ray_generator.sv */
// thin-lens camera ray generator, fully pipelined
// throughput: one item per clock cycle, busy is always low
// stages: 10 setup stages, 33 square root stages, 32 divide stages and the
//   output register carry an item from the accepting edge to the result strobe
// the receiver cannot stall; synchronous active-high reset clears all valid
//   bits and loads the register reset values, in-flight items are dropped
module thin_lens_ray_generator
   import tlrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [15:0] req_jitter_x,
   input  logic [15:0] req_jitter_y,
   input  logic signed [31:0] req_disc_u,
   input  logic signed [31:0] req_disc_v,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_origin_x,
   output logic signed [31:0] rsp_origin_z,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic signed [31:0] rsp_dir_z,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration registers
   logic [11:0] hw_ff, hh_ff;
   logic [31:0] pw_ff, ph_ff, ap_ff, fl_ff, sd_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= '0;
         hh_ff <= '0;
         pw_ff <= '0;
         ph_ff <= '0;
         ap_ff <= '0;
         fl_ff <= ONE_Q24;
         sd_ff <= ONE_Q24;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HALF_WIDTH:   hw_ff <= csr_data[11:0];
            REG_HALF_HEIGHT:  hh_ff <= csr_data[11:0];
            REG_PIXEL_SIZE_X: pw_ff <= csr_data;
            REG_PIXEL_SIZE_Y: ph_ff <= csr_data;
            REG_APERTURE:     ap_ff <= csr_data;
            REG_FOCAL_LEN:    fl_ff <= csr_data;
            REG_SENSOR_DIST:  sd_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: subpixel coordinates in q.16
   logic        s1_vld_ff;
   logic [28:0] s1_sx_ff, s1_sy_ff, s1_sx_in, s1_sy_in;
   logic [31:0] s1_du_ff, s1_dv_ff;
   logic [12:0] dx_c, dy_c;

   always_comb begin
      dx_c = {1'b0, clamp_pixel(req_pixel_x)} - {1'b0, hw_ff};
      dy_c = {1'b0, clamp_pixel(req_pixel_y)} - {1'b0, hh_ff};
      s1_sx_in = {dx_c, req_jitter_x};
      s1_sy_in = {dy_c, req_jitter_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_sx_ff <= s1_sx_in;
      s1_sy_ff <= s1_sy_in;
      s1_du_ff <= req_disc_u;
      s1_dv_ff <= req_disc_v;
   end

   // stage 2: magnitude products for origin and pixel point
   logic        s2_vld_ff;
   logic [63:0] s2_pox_ff, s2_poz_ff, s2_ppx_ff, s2_ppz_ff;
   logic        s2_nu_ff, s2_nv_ff, s2_nsx_ff, s2_nsy_ff;
   logic [31:0] dum_c, dvm_c;
   logic [28:0] sxm_c, sym_c;

   always_comb begin
      dum_c = s1_du_ff[31] ? 32'd0 - s1_du_ff : s1_du_ff;
      dvm_c = s1_dv_ff[31] ? 32'd0 - s1_dv_ff : s1_dv_ff;
      sxm_c = s1_sx_ff[28] ? 29'd0 - s1_sx_ff : s1_sx_ff;
      sym_c = s1_sy_ff[28] ? 29'd0 - s1_sy_ff : s1_sy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_pox_ff <= 64'(dum_c) * 64'(ap_ff);
      s2_poz_ff <= 64'(dvm_c) * 64'(ap_ff);
      s2_ppx_ff <= 64'(sxm_c) * 64'(pw_ff);
      s2_ppz_ff <= 64'(sym_c) * 64'(ph_ff);
      s2_nu_ff  <= s1_du_ff[31];
      s2_nv_ff  <= s1_dv_ff[31];
      s2_nsx_ff <= s1_sx_ff[28];
      s2_nsy_ff <= s1_sy_ff[28];
   end

   // stage 3: shift, sign and saturate; pixel point is negated
   logic        s3_vld_ff;
   logic [31:0] s3_ox_ff, s3_oz_ff, s3_px_ff, s3_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_ox_ff <= sat32(s2_nu_ff, s2_pox_ff >> 30);
      s3_oz_ff <= sat32(s2_nv_ff, s2_poz_ff >> 30);
      s3_px_ff <= sat32(!s2_nsx_ff, s2_ppx_ff >> 16);
      s3_pz_ff <= sat32(!s2_nsy_ff, s2_ppz_ff >> 16);
   end

   // stage 4: products of the direction terms
   logic        s4_vld_ff;
   logic [63:0] s4_a0_ff, s4_b0_ff, s4_a2_ff, s4_b2_ff, s4_fd_ff;
   logic        s4_sa0_ff, s4_sb0_ff, s4_sa2_ff, s4_sb2_ff;
   logic [31:0] s4_ox_ff, s4_oz_ff;
   logic [32:0] fmd_c;
   logic [31:0] fmm_c, oxm_c, ozm_c, pxm_c, pzm_c;

   always_comb begin
      fmd_c = {1'b0, fl_ff} - {1'b0, sd_ff};
      fmm_c = fmd_c[32] ? 32'(33'd0 - fmd_c) : fmd_c[31:0];
      oxm_c = s3_ox_ff[31] ? 32'd0 - s3_ox_ff : s3_ox_ff;
      ozm_c = s3_oz_ff[31] ? 32'd0 - s3_oz_ff : s3_oz_ff;
      pxm_c = s3_px_ff[31] ? 32'd0 - s3_px_ff : s3_px_ff;
      pzm_c = s3_pz_ff[31] ? 32'd0 - s3_pz_ff : s3_pz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_a0_ff  <= 64'(oxm_c) * 64'(fmm_c);
      s4_a2_ff  <= 64'(ozm_c) * 64'(fmm_c);
      s4_b0_ff  <= 64'(pxm_c) * 64'(fl_ff);
      s4_b2_ff  <= 64'(pzm_c) * 64'(fl_ff);
      s4_fd_ff  <= 64'(fl_ff) * 64'(sd_ff);
      s4_sa0_ff <= fmd_c[32] ^ s3_ox_ff[31];
      s4_sa2_ff <= fmd_c[32] ^ s3_oz_ff[31];
      s4_sb0_ff <= s3_px_ff[31];
      s4_sb2_ff <= s3_pz_ff[31];
      s4_ox_ff  <= s3_ox_ff;
      s4_oz_ff  <= s3_oz_ff;
   end

   // stage 5: direction vector in q.46
   logic        s5_vld_ff;
   logic [63:0] s5_v_ff [0:2];
   logic [31:0] s5_ox_ff, s5_oz_ff;
   logic [63:0] ta0_c, tb0_c, ta2_c, tb2_c;

   always_comb begin
      ta0_c = s4_sa0_ff ? 64'd0 - (s4_a0_ff >> 2) : (s4_a0_ff >> 2);
      tb0_c = s4_sb0_ff ? 64'd0 - (s4_b0_ff >> 2) : (s4_b0_ff >> 2);
      ta2_c = s4_sa2_ff ? 64'd0 - (s4_a2_ff >> 2) : (s4_a2_ff >> 2);
      tb2_c = s4_sb2_ff ? 64'd0 - (s4_b2_ff >> 2) : (s4_b2_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      s5_v_ff[0] <= ta0_c - tb0_c;
      s5_v_ff[1] <= s4_fd_ff >> 2;
      s5_v_ff[2] <= ta2_c - tb2_c;
      s5_ox_ff   <= s4_ox_ff;
      s5_oz_ff   <= s4_oz_ff;
   end

   // stage 6: component magnitudes
   logic        s6_vld_ff;
   logic [62:0] s6_m_ff [0:2];
   side_type    s6_side_ff;
   logic [63:0] vm_c [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vm_c[i] = s5_v_ff[i][63] ? 64'd0 - s5_v_ff[i] : s5_v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s6_m_ff[i] <= vm_c[i][62:0];
      end
      s6_side_ff.ox   <= s5_ox_ff;
      s6_side_ff.oz   <= s5_oz_ff;
      s6_side_ff.neg  <= {s5_v_ff[2][63], s5_v_ff[1][63], s5_v_ff[0][63]};
      s6_side_ff.zero <= 1'b0;
   end

   // stage 7: largest magnitude
   logic        s7_vld_ff;
   logic [62:0] s7_m_ff [0:2];
   logic [62:0] s7_mx_ff;
   side_type    s7_side_ff;
   logic [62:0] mx01_c;

   always_comb begin
      mx01_c = (s6_m_ff[1] > s6_m_ff[0]) ? s6_m_ff[1] : s6_m_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s6_vld_ff;
      end
      s7_m_ff    <= s6_m_ff;
      s7_mx_ff   <= (s6_m_ff[2] > mx01_c) ? s6_m_ff[2] : mx01_c;
      s7_side_ff <= s6_side_ff;
   end

   // stage 8: bit length of the largest magnitude
   logic        s8_vld_ff;
   logic [62:0] s8_m_ff [0:2];
   logic [5:0]  s8_len_ff;
   side_type    s8_side_ff;
   logic [5:0]  len_c;

   always_comb begin
      len_c = '0;
      for (int i = 0; i < 63; i++) begin
         if (s7_mx_ff[i]) begin
            len_c = 6'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else begin
         s8_vld_ff <= s7_vld_ff;
      end
      s8_m_ff    <= s7_m_ff;
      s8_len_ff  <= len_c;
      s8_side_ff <= {s7_side_ff.ox, s7_side_ff.oz, s7_side_ff.neg, (s7_mx_ff == '0)};
   end

   // stage 9: common shift so the largest lies in [2^30, 2^31)
   logic        s9_vld_ff;
   logic [30:0] s9_m_ff [0:2];
   side_type    s9_side_ff;
   logic [62:0] nm_c [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s8_len_ff > 6'd31) begin
            nm_c[i] = s8_m_ff[i] >> (s8_len_ff - 6'd31);
         end else begin
            nm_c[i] = s8_m_ff[i] << (6'd31 - s8_len_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else begin
         s9_vld_ff <= s8_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s9_m_ff[i] <= nm_c[i][30:0];
      end
      s9_side_ff <= s8_side_ff;
   end

   // stage 10: squares
   logic        s10_vld_ff;
   logic [61:0] s10_sq_ff [0:2];
   logic [30:0] s10_m_ff [0:2];
   side_type    s10_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else begin
         s10_vld_ff <= s9_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s10_sq_ff[i] <= 62'(s9_m_ff[i]) * 62'(s9_m_ff[i]);
      end
      s10_m_ff    <= s9_m_ff;
      s10_side_ff <= s9_side_ff;
   end

   // square root pipeline, element 0 holds the sum of squares
   logic        sq_vld_ff  [0:SQRT_STEPS];
   logic [63:0] sq_n_ff    [0:SQRT_STEPS];
   logic [34:0] sq_rem_ff  [0:SQRT_STEPS];
   logic [31:0] sq_q_ff    [0:SQRT_STEPS];
   logic [30:0] sq_m_ff    [0:SQRT_STEPS][0:2];
   side_type    sq_side_ff [0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s10_vld_ff;
      end
      sq_n_ff[0]    <= 64'(s10_sq_ff[0]) + 64'(s10_sq_ff[1]) + 64'(s10_sq_ff[2]);
      sq_rem_ff[0]  <= '0;
      sq_q_ff[0]    <= '0;
      sq_m_ff[0]    <= s10_m_ff;
      sq_side_ff[0] <= s10_side_ff;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [34:0] rem_sh;
      logic [34:0] trial;

      // one root bit: bring down two bits, try subtracting 4q+1
      always_comb begin
         rem_sh = {sq_rem_ff[k][32:0], sq_n_ff[k][63:62]};
         trial  = {1'b0, sq_q_ff[k], 2'b01};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         sq_n_ff[k+1] <= sq_n_ff[k] << 2;
         if (rem_sh >= trial) begin
            sq_rem_ff[k+1] <= rem_sh - trial;
            sq_q_ff[k+1]   <= {sq_q_ff[k][30:0], 1'b1};
         end else begin
            sq_rem_ff[k+1] <= rem_sh;
            sq_q_ff[k+1]   <= {sq_q_ff[k][30:0], 1'b0};
         end
         sq_m_ff[k+1]    <= sq_m_ff[k];
         sq_side_ff[k+1] <= sq_side_ff[k];
      end
   end

   // divide pipeline: q = (m << 30) / s for three lanes
   logic        dv_vld_ff  [0:DIV_STEPS];
   logic [31:0] dv_s_ff    [0:DIV_STEPS];
   logic [31:0] dv_rem_ff  [0:DIV_STEPS][0:2];
   logic [30:0] dv_q_ff    [0:DIV_STEPS][0:2];
   logic        dv_b_ff    [0:DIV_STEPS][0:2];
   side_type    dv_side_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQRT_STEPS];
      end
      dv_s_ff[0] <= sq_q_ff[SQRT_STEPS];
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= {2'b00, sq_m_ff[SQRT_STEPS][i][30:1]};
         dv_b_ff[0][i]   <= sq_m_ff[SQRT_STEPS][i][0];
         dv_q_ff[0][i]   <= '0;
      end
      dv_side_ff[0] <= sq_side_ff[SQRT_STEPS];
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [32:0] rsh [0:2];

      // one quotient bit per lane
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rsh[i] = {dv_rem_ff[j][i], dv_b_ff[j][i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         dv_s_ff[j+1] <= dv_s_ff[j];
         for (int i = 0; i < 3; i++) begin
            dv_b_ff[j+1][i] <= 1'b0;
            if (rsh[i] >= {1'b0, dv_s_ff[j]}) begin
               dv_rem_ff[j+1][i] <= 32'(rsh[i] - {1'b0, dv_s_ff[j]});
               dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][29:0], 1'b1};
            end else begin
               dv_rem_ff[j+1][i] <= rsh[i][31:0];
               dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][29:0], 1'b0};
            end
         end
         dv_side_ff[j+1] <= dv_side_ff[j];
      end
   end

   // output register: apply signs, zero vector gives zero direction
   logic        out_vld_ff;
   logic [31:0] out_ox_ff, out_oz_ff;
   logic [31:0] out_d_ff [0:2];
   logic [31:0] dq_c [0:2];
   side_type    fin_c;

   always_comb begin
      fin_c = dv_side_ff[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
         if (fin_c.zero) begin
            dq_c[i] = '0;
         end else if (fin_c.neg[i]) begin
            dq_c[i] = 32'd0 - {1'b0, dv_q_ff[DIV_STEPS][i]};
         end else begin
            dq_c[i] = {1'b0, dv_q_ff[DIV_STEPS][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[DIV_STEPS];
      end
      out_ox_ff <= fin_c.ox;
      out_oz_ff <= fin_c.oz;
      out_d_ff  <= dq_c;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_origin_x = out_ox_ff;
   assign rsp_origin_z = out_oz_ff;
   assign rsp_dir_x    = out_d_ff[0];
   assign rsp_dir_y    = out_d_ff[1];
   assign rsp_dir_z    = out_d_ff[2];

endmodule
